[rtl/core/awdu_pkg.sv]
package awdu_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FRAC_BITS     = 12;

    localparam int DATA_W  = 16;
    localparam int SIG_W   = FRAC_BITS + 1;
    localparam int TIDX_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int REM_W   = FRAC_BITS + 3;
    localparam int PROD_W  = 2 * DATA_W + 1;
    localparam int Z_W     = PROD_W + 1;
    localparam int POS_W   = Z_W + TIDX_W;
    localparam int SLOPE_W = FRAC_BITS;
    localparam int G_W     = 16;
    localparam int DRV_W   = Z_W - FRAC_BITS;
    localparam int RES_W0  = (DRV_W > FRAC_BITS + 2) ? DRV_W : FRAC_BITS + 2;
    localparam int RES_W   = (RES_W0 > DATA_W + 1) ? RES_W0 : DATA_W + 1;
    localparam int NSTAGE  = 9;
    localparam int HALF    = 1 << (FRAC_BITS - 1);

    // One table step, 8/TABLE_ENTRIES, in Q32.
    localparam longint unsigned STEP_Q32 = (64'd8 << 32) / TABLE_ENTRIES;

    localparam logic [SIG_W-1:0]        ONE_SIG = SIG_W'(1) << FRAC_BITS;
    localparam logic signed [RES_W-1:0] ONE_RES = RES_W'(1) << FRAC_BITS;
    localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(32767);
    localparam logic signed [RES_W-1:0] SAT_MIN = -RES_W'(32768);
    localparam logic [DATA_W-1:0]       BETA_RESET = 16'd4096;

    typedef enum logic [1:0] {
        CMD_ACT   = 2'd0,
        CMD_SLOPE = 2'd1,
        CMD_GRAD  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SIGMOID  = 2'd0,
        KIND_STEP     = 2'd1,
        KIND_IDENTITY = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CFG_KIND = 1'b0,
        CFG_BETA = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_cmd                     cmd;
        t_kind                    kind;
        logic [DATA_W-1:0]        beta;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] f;
    } t_side;

    typedef struct packed {
        logic              in_ready;
        logic              out_valid;
        logic [NSTAGE-1:0] load;
    } t_pipe_ctl;

    typedef logic [SIG_W-1:0] t_sig_tab [0:TABLE_ENTRIES];

    // Shift-and-subtract long division for the table build at elaboration.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        logic [64:0]     part;
        quo  = '0;
        part = '0;
        for (int b = 63; b >= 0; b--) begin
            part = {part[63:0], num[b]};
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Sigmoid samples at t = 8*i/TABLE_ENTRIES, built at elaboration from Q32 terms and stored in Q1.12.
    function automatic t_sig_tab build_sig_table();
        t_sig_tab           tab;
        longint unsigned    one32;
        longint unsigned    d;
        longint unsigned    term;
        longint unsigned    e1;
        longint unsigned    e;
        longint unsigned    den;
        longint unsigned    num;
        longint             sum;
        one32 = 64'd1 << 32;
        d     = STEP_Q32;
        sum   = longint'(one32);
        term  = one32;
        for (int k = 1; k <= 14; k++) begin
            term = div_u64((term * d) >> 32, 64'(k));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        e1  = longint'(sum);
        e   = one32;
        num = 64'd1 << (32 + FRAC_BITS);
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            den    = one32 + e;
            tab[k] = SIG_W'(div_u64(num + (den >> 1), den));
            e      = (e * e1) >> 32;
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TABLE = build_sig_table();

endpackage

[rtl/core/awdu_pipe_ctrl.sv]
module awdu_pipe_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output awdu_pkg::t_pipe_ctl   o_ctl
);

    logic [awdu_pkg::NSTAGE-1:0] r_vld;
    logic [awdu_pkg::NSTAGE-1:0] n_vld;
    logic [awdu_pkg::NSTAGE:0]   can_take;

    // A stage takes new content when it is empty or its content moves on.
    always_comb begin
        can_take[awdu_pkg::NSTAGE] = i_out_ready;
        for (int k = awdu_pkg::NSTAGE - 1; k >= 0; k--) begin
            can_take[k] = !r_vld[k] || can_take[k+1];
        end
    end

    always_comb begin
        n_vld[0] = can_take[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < awdu_pkg::NSTAGE; k++) begin
            n_vld[k] = can_take[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.in_ready  = can_take[0];
    assign o_ctl.out_valid = r_vld[awdu_pkg::NSTAGE-1];
    assign o_ctl.load      = can_take[awdu_pkg::NSTAGE-1:0];

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[awdu_pkg::NSTAGE-1] && !i_out_ready |=> r_vld[awdu_pkg::NSTAGE-1])
        else $error("result lost while stalled");

    a_empty_tail_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[awdu_pkg::NSTAGE-1] |-> o_ctl.in_ready)
        else $error("input stalled with empty output stage");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_vld) + $past(32'(r_vld[awdu_pkg::NSTAGE-1] && i_out_ready))
            == $past($countones(r_vld)) + $past(32'(i_in_valid && can_take[0])))
        else $error("items created or dropped in pipeline");

endmodule

[rtl/core/awdu_sigmoid.sv]
module awdu_sigmoid (
    input  logic                              i_clk,
    input  logic [4:0]                        i_load,
    input  logic [awdu_pkg::DATA_W-1:0]       i_beta,
    input  logic signed [awdu_pkg::DATA_W-1:0] i_x,
    output logic [awdu_pkg::SIG_W-1:0]        o_s,
    output logic [awdu_pkg::SIG_W-1:0]        o_sc
);

    localparam int IP_W = awdu_pkg::SIG_W + awdu_pkg::REM_W;

    logic signed [awdu_pkg::PROD_W-1:0] r0_prod;

    logic                               r1_sat;
    logic [awdu_pkg::TIDX_W-1:0]        r1_idx;
    logic [awdu_pkg::REM_W-1:0]         r1_rem;
    logic                               r1_neg;

    logic [awdu_pkg::SIG_W-1:0]         r2_lo;
    logic [awdu_pkg::SIG_W-1:0]         r2_diff;
    logic [awdu_pkg::REM_W-1:0]         r2_rem;
    logic                               r2_neg;

    logic [awdu_pkg::SIG_W-1:0]         r3_m;
    logic                               r3_neg;

    logic [awdu_pkg::SIG_W-1:0]         r4_s;
    logic [awdu_pkg::SIG_W-1:0]         r4_sc;

    logic signed [awdu_pkg::Z_W-1:0]    zsum;
    logic signed [awdu_pkg::Z_W-1:0]    z;
    logic [awdu_pkg::Z_W-1:0]           mag;
    logic [awdu_pkg::POS_W-1:0]         pos;
    logic [awdu_pkg::POS_W-1:0]         idx_full;
    logic [awdu_pkg::TIDX_W-1:0]        idx_hi;
    logic [awdu_pkg::SIG_W-1:0]         tab_lo;
    logic [awdu_pkg::SIG_W-1:0]         tab_hi;
    logic [IP_W-1:0]                    ip;

    // Gain rounding with ties upward, then split |z| into table index and remainder.
    always_comb begin
        zsum     = awdu_pkg::Z_W'(r0_prod) + awdu_pkg::Z_W'(awdu_pkg::HALF);
        z        = zsum >>> awdu_pkg::FRAC_BITS;
        mag      = z[awdu_pkg::Z_W-1] ? awdu_pkg::Z_W'(-z) : awdu_pkg::Z_W'(z);
        pos      = awdu_pkg::POS_W'(mag) * awdu_pkg::POS_W'(awdu_pkg::TABLE_ENTRIES);
        idx_full = pos >> (awdu_pkg::FRAC_BITS + 3);
    end

    always_comb begin
        idx_hi = r1_idx + awdu_pkg::TIDX_W'(1);
        if (r1_sat) begin
            tab_lo = awdu_pkg::SIG_TABLE[awdu_pkg::TABLE_ENTRIES];
            tab_hi = awdu_pkg::SIG_TABLE[awdu_pkg::TABLE_ENTRIES];
        end else begin
            tab_lo = awdu_pkg::SIG_TABLE[r1_idx];
            tab_hi = awdu_pkg::SIG_TABLE[idx_hi];
        end
    end

    // The table rises monotonically, so the interpolation product is never negative.
    assign ip = IP_W'(r2_diff) * IP_W'(r2_rem);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r0_prod <= $signed({1'b0, i_beta}) * i_x;
        end
        if (i_load[1]) begin
            r1_sat <= idx_full >= awdu_pkg::POS_W'(awdu_pkg::TABLE_ENTRIES);
            r1_idx <= idx_full[awdu_pkg::TIDX_W-1:0];
            r1_rem <= pos[awdu_pkg::REM_W-1:0];
            r1_neg <= z[awdu_pkg::Z_W-1];
        end
        if (i_load[2]) begin
            r2_lo   <= tab_lo;
            r2_diff <= tab_hi - tab_lo;
            r2_rem  <= r1_rem;
            r2_neg  <= r1_neg;
        end
        if (i_load[3]) begin
            r3_m   <= r2_lo + ip[IP_W-1:awdu_pkg::REM_W];
            r3_neg <= r2_neg;
        end
        if (i_load[4]) begin
            r4_s  <= r3_neg ? awdu_pkg::ONE_SIG - r3_m : r3_m;
            r4_sc <= r3_neg ? r3_m : awdu_pkg::ONE_SIG - r3_m;
        end
    end

    assign o_s  = r4_s;
    assign o_sc = r4_sc;

endmodule

[rtl/core/awdu_deriv.sv]
module awdu_deriv (
    input  logic                               i_clk,
    input  logic [2:0]                         i_load,
    input  logic [awdu_pkg::SIG_W-1:0]         i_s,
    input  logic [awdu_pkg::SIG_W-1:0]         i_sc,
    input  logic [awdu_pkg::DATA_W-1:0]        i_beta,
    input  logic signed [awdu_pkg::DATA_W-1:0] i_factor,
    output logic [awdu_pkg::SIG_W-1:0]         o_s,
    output logic [awdu_pkg::SLOPE_W-1:0]       o_slope,
    output logic signed [awdu_pkg::DRV_W-1:0]  o_deriv
);

    localparam int SP_W = 2 * awdu_pkg::SIG_W + 1;
    localparam int GP_W = awdu_pkg::SLOPE_W + awdu_pkg::DATA_W + 1;

    logic [awdu_pkg::SIG_W-1:0]         r5_s;
    logic [awdu_pkg::SLOPE_W-1:0]       r5_slope;
    logic [awdu_pkg::SIG_W-1:0]         r6_s;
    logic [awdu_pkg::SLOPE_W-1:0]       r6_slope;
    logic [awdu_pkg::G_W-1:0]           r6_g;
    logic [awdu_pkg::SIG_W-1:0]         r7_s;
    logic [awdu_pkg::SLOPE_W-1:0]       r7_slope;
    logic signed [awdu_pkg::DRV_W-1:0]  r7_deriv;

    logic [SP_W-1:0]                    sp;
    logic [GP_W-1:0]                    gp;
    logic signed [awdu_pkg::Z_W-1:0]    dp;

    always_comb begin
        sp = SP_W'(i_s) * SP_W'(i_sc) + SP_W'(awdu_pkg::HALF);
        gp = GP_W'(r5_slope) * GP_W'(i_beta) + GP_W'(awdu_pkg::HALF);
        dp = $signed({1'b0, r6_g}) * i_factor;
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r5_s     <= i_s;
            r5_slope <= sp[awdu_pkg::FRAC_BITS+awdu_pkg::SLOPE_W-1:awdu_pkg::FRAC_BITS];
        end
        if (i_load[1]) begin
            r6_s     <= r5_s;
            r6_slope <= r5_slope;
            r6_g     <= gp[awdu_pkg::FRAC_BITS+awdu_pkg::G_W-1:awdu_pkg::FRAC_BITS];
        end
        if (i_load[2]) begin
            r7_s     <= r6_s;
            r7_slope <= r6_slope;
            r7_deriv <= $signed(awdu_pkg::DRV_W'(
                (dp + awdu_pkg::Z_W'(awdu_pkg::HALF)) >>> awdu_pkg::FRAC_BITS));
        end
    end

    assign o_s     = r7_s;
    assign o_slope = r7_slope;
    assign o_deriv = r7_deriv;

endmodule

[rtl/core/activation_with_derivative_unit_top.sv]
// Channel  Direction  Handshake                  Payload
// in       in         i_in_valid / o_in_ready    i_cmd, i_x_value, i_factor
// out      out        o_out_valid / i_out_ready  o_result_value, o_unsupported, o_saturated
// cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Nine register stages: gain product, index split, table read, interpolation,
// sign fold, slope product, gain product, factor product, select and clip.
// One item per cycle while the output is not stalled.
// Synchronous active-low reset empties the pipeline and restores the kind and gain registers.
// A stall at the output fills empty stages first, then holds every stage in place.
module activation_with_derivative_unit_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_cmd,
    input  logic signed [awdu_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [awdu_pkg::DATA_W-1:0] i_factor,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [awdu_pkg::DATA_W-1:0] o_result_value,
    output logic                               o_unsupported,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [0:0]                         i_cfg_index,
    input  logic [awdu_pkg::DATA_W-1:0]        i_cfg_data
);

    localparam int LAST = awdu_pkg::NSTAGE - 2;

    awdu_pkg::t_pipe_ctl                ctl;
    awdu_pkg::t_side                    r_side [0:LAST];
    awdu_pkg::t_side                    in_side;

    logic [1:0]                         r_kind;
    logic [awdu_pkg::DATA_W-1:0]        r_beta;

    logic [awdu_pkg::SIG_W-1:0]         sig_s;
    logic [awdu_pkg::SIG_W-1:0]         sig_sc;
    logic [awdu_pkg::SIG_W-1:0]         drv_s;
    logic [awdu_pkg::SLOPE_W-1:0]       drv_slope;
    logic signed [awdu_pkg::DRV_W-1:0]  drv_deriv;

    logic signed [awdu_pkg::RES_W-1:0]  n_wide;
    logic                               n_unsup;
    logic signed [awdu_pkg::DATA_W-1:0] n_res;
    logic                               n_sat;

    logic signed [awdu_pkg::DATA_W-1:0] r_res;
    logic                               r_unsup;
    logic                               r_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= awdu_pkg::KIND_SIGMOID;
            r_beta <= awdu_pkg::BETA_RESET;
        end else if (i_cfg_valid) begin
            unique case (awdu_pkg::t_cfg_reg'(i_cfg_index))
                awdu_pkg::CFG_KIND: r_kind <= i_cfg_data[1:0];
                awdu_pkg::CFG_BETA: r_beta <= i_cfg_data;
            endcase
        end
    end

    awdu_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    assign o_in_ready  = ctl.in_ready;
    assign o_out_valid = ctl.out_valid;

    always_comb begin
        in_side.cmd  = awdu_pkg::t_cmd'(i_cmd);
        in_side.kind = awdu_pkg::t_kind'(r_kind);
        in_side.beta = r_beta;
        in_side.x    = i_x_value;
        in_side.f    = i_factor;
    end

    // Command, kind and operands ride alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (ctl.load[0]) begin
            r_side[0] <= in_side;
        end
        for (int k = 1; k <= LAST; k++) begin
            if (ctl.load[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    awdu_sigmoid u_sigmoid (
        .i_clk  (i_clk),
        .i_load (ctl.load[4:0]),
        .i_beta (r_beta),
        .i_x    (i_x_value),
        .o_s    (sig_s),
        .o_sc   (sig_sc)
    );

    awdu_deriv u_deriv (
        .i_clk    (i_clk),
        .i_load   (ctl.load[7:5]),
        .i_s      (sig_s),
        .i_sc     (sig_sc),
        .i_beta   (r_side[5].beta),
        .i_factor (r_side[6].f),
        .o_s      (drv_s),
        .o_slope  (drv_slope),
        .o_deriv  (drv_deriv)
    );

    always_comb begin
        n_wide  = '0;
        n_unsup = 1'b0;
        case (r_side[LAST].kind)
            awdu_pkg::KIND_SIGMOID: begin
                case (r_side[LAST].cmd)
                    awdu_pkg::CMD_ACT:   n_wide = $signed(awdu_pkg::RES_W'(drv_s));
                    awdu_pkg::CMD_SLOPE: n_wide = $signed(awdu_pkg::RES_W'(drv_slope));
                    awdu_pkg::CMD_GRAD:  n_wide = awdu_pkg::RES_W'(drv_deriv);
                    default:             n_unsup = 1'b1;
                endcase
            end
            awdu_pkg::KIND_STEP: begin
                case (r_side[LAST].cmd)
                    awdu_pkg::CMD_ACT: begin
                        n_wide = (r_side[LAST].x > 16'sd0) ? awdu_pkg::ONE_RES : '0;
                    end
                    default: n_unsup = 1'b1;
                endcase
            end
            awdu_pkg::KIND_IDENTITY: begin
                case (r_side[LAST].cmd)
                    awdu_pkg::CMD_ACT:   n_wide = awdu_pkg::RES_W'(r_side[LAST].x);
                    awdu_pkg::CMD_SLOPE: n_wide = awdu_pkg::ONE_RES;
                    awdu_pkg::CMD_GRAD:  n_wide = awdu_pkg::RES_W'(r_side[LAST].f);
                    default:             n_unsup = 1'b1;
                endcase
            end
            default: n_unsup = 1'b1;
        endcase

        n_sat = 1'b0;
        if (n_wide > awdu_pkg::SAT_MAX) begin
            n_res = awdu_pkg::DATA_W'(awdu_pkg::SAT_MAX);
            n_sat = 1'b1;
        end else if (n_wide < awdu_pkg::SAT_MIN) begin
            n_res = awdu_pkg::DATA_W'(awdu_pkg::SAT_MIN);
            n_sat = 1'b1;
        end else begin
            n_res = n_wide[awdu_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[awdu_pkg::NSTAGE-1]) begin
            r_res   <= n_res;
            r_unsup <= n_unsup;
            r_sat   <= n_sat;
        end
    end

    assign o_result_value = r_res;
    assign o_unsupported  = r_unsup;
    assign o_saturated    = r_sat;

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_unsupported |-> o_result_value == '0 && !o_saturated)
        else $error("unsupported result carries a value");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            o_result_value == 16'sh7FFF || o_result_value == 16'sh8000)
        else $error("clipped result is not at a range limit");

    a_sigmoid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_unsupported && $past(r_side[LAST].kind == awdu_pkg::KIND_SIGMOID)
            && $past(ctl.load[awdu_pkg::NSTAGE-1]) && $past(r_side[LAST].cmd != awdu_pkg::CMD_GRAD)
            |-> o_result_value >= 16'sd0)
        else $error("sigmoid value or slope negative");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import awdu_pkg::*;

    localparam int      FB         = awdu_pkg::FRAC_BITS;
    localparam int      N_SAMP     = awdu_pkg::TABLE_ENTRIES;
    localparam longint  ONE_Q      = longint'(1) << FB;
    localparam longint  HALF_Q     = longint'(1) << (FB - 1);
    localparam longint  RANGE_Q    = longint'(8) << FB;
    localparam int      IDLE_LIMIT = 2000;
    localparam int      MAX_GAP    = 18;

    // Code three of the command and of the kind lies outside the package enums.
    localparam logic [1:0] CMD_BAD  = 2'd3;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        logic signed [15:0] value;
        logic               unsup;
        logic               sat;
    } t_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] beta;
        logic [1:0]  cmd;
        logic [15:0] x;
        logic [15:0] f;
        logic        lit;
        logic [15:0] res;
        logic        uns;
        logic        sat;
    } t_row;

    // Rows with lit set carry their expected result; the others go through the predictor.
    localparam t_row DIRECTED_ROWS [25] = '{
        '{KIND_SIGMOID,  16'h1000, CMD_ACT,   16'h0000, 16'h0000, 1'b1, 16'h0800, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_SLOPE, 16'h0000, 16'h0000, 1'b1, 16'h0400, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_GRAD,  16'h0000, 16'h7FFF, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_ACT,   16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_ACT,   16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_SLOPE, 16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_GRAD,  16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h1000, CMD_BAD,   16'h1234, 16'h4321, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{KIND_SIGMOID,  16'hFFFF, CMD_GRAD,  16'h0000, 16'h7FFF, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'hFFFF, CMD_GRAD,  16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'hFFFF, CMD_ACT,   16'h0001, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h0000, CMD_ACT,   16'h7FFF, 16'h0000, 1'b1, 16'h0800, 1'b0, 1'b0},
        '{KIND_SIGMOID,  16'h0000, CMD_GRAD,  16'h7FFF, 16'h7FFF, 1'b1, 16'h0000, 1'b0, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_ACT,   16'h0001, 16'h0000, 1'b1, 16'h1000, 1'b0, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_ACT,   16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_ACT,   16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_ACT,   16'h7FFF, 16'h0000, 1'b1, 16'h1000, 1'b0, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_SLOPE, 16'h0100, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{KIND_STEP,     16'h1000, CMD_GRAD,  16'h0100, 16'h7FFF, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{KIND_IDENTITY, 16'h1000, CMD_ACT,   16'h8000, 16'h0000, 1'b1, 16'h8000, 1'b0, 1'b0},
        '{KIND_IDENTITY, 16'h1000, CMD_ACT,   16'h7FFF, 16'h0000, 1'b1, 16'h7FFF, 1'b0, 1'b0},
        '{KIND_IDENTITY, 16'h1000, CMD_SLOPE, 16'h1234, 16'h0000, 1'b1, 16'h1000, 1'b0, 1'b0},
        '{KIND_IDENTITY, 16'h1000, CMD_GRAD,  16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b0, 1'b0},
        '{KIND_IDENTITY, 16'h1000, CMD_BAD,   16'h0001, 16'h0001, 1'b1, 16'h0000, 1'b1, 1'b0},
        '{KIND_BAD,      16'h1000, CMD_ACT,   16'h0800, 16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_cmd;
    logic signed [15:0] i_x_value;
    logic signed [15:0] i_factor;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_result_value;
    logic               o_unsupported;
    logic               o_saturated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // Register copy kept by the testbench, starting from the reset values.
    logic [1:0]  act_kind  = KIND_SIGMOID;
    logic [15:0] beta_gain = BETA_RESET;

    longint  sigmoid_samples [0:N_SAMP];
    t_result pending_results [$];
    int      error_count = 0;
    bit      no_idle     = 1'b0;

    activation_with_derivative_unit_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_x_value      (i_x_value),
        .i_factor       (i_factor),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_unsupported  (o_unsupported),
        .o_saturated    (o_saturated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sigmoid samples in Q1.12 from Q32 arithmetic: e^-t for one table step from a Taylor series,
    // then powers of it by truncating products.
    initial begin : build_samples
        longint unsigned one32;
        longint unsigned step_q;
        longint unsigned term;
        longint unsigned e1;
        longint unsigned e;
        longint unsigned den;
        longint          acc;
        one32  = 64'd1 << 32;
        step_q = (64'd8 << 32) / N_SAMP;
        acc    = one32;
        term   = one32;
        for (int k = 1; k <= 14; k++) begin
            term = ((term * step_q) >> 32) / k;
            if ((k % 2) == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        e1 = acc;
        e  = one32;
        for (int k = 0; k <= N_SAMP; k++) begin
            den                = one32 + e;
            sigmoid_samples[k] = ((64'd1 << (32 + FB)) + den / 2) / den;
            e                  = (e * e1) >> 32;
        end
    end

    function automatic t_result compute_activation_result(logic [1:0] cmd,
                                                          logic signed [15:0] x,
                                                          logic signed [15:0] f);
        t_result r;
        longint  val;
        longint  z;
        longint  mag;
        longint  pos;
        longint  idx;
        longint  rem;
        longint  s;
        longint  slope;
        longint  gain;
        logic    bad;
        val = 0;
        bad = 1'b0;
        if (cmd == CMD_BAD || act_kind == KIND_BAD) begin
            bad = 1'b1;
        end else if (act_kind == KIND_SIGMOID) begin
            // Rounding adds half an LSB and shifts arithmetically, so ties go upward.
            z   = (longint'(beta_gain) * longint'(x) + HALF_Q) >>> FB;
            mag = (z < 0) ? -z : z;
            pos = mag * N_SAMP;
            idx = pos / RANGE_Q;
            rem = pos % RANGE_Q;
            if (idx >= N_SAMP) begin
                s = sigmoid_samples[N_SAMP];
            end else begin
                s = sigmoid_samples[idx]
                    + ((sigmoid_samples[idx + 1] - sigmoid_samples[idx]) * rem) / RANGE_Q;
            end
            if (z < 0) begin
                s = ONE_Q - s;
            end
            if (cmd == CMD_ACT) begin
                val = s;
            end else begin
                slope = (s * (ONE_Q - s) + HALF_Q) >>> FB;
                if (cmd == CMD_SLOPE) begin
                    val = slope;
                end else begin
                    gain = (slope * longint'(beta_gain) + HALF_Q) >>> FB;
                    val  = (gain * longint'(f) + HALF_Q) >>> FB;
                end
            end
        end else if (act_kind == KIND_STEP) begin
            if (cmd == CMD_ACT) begin
                val = (x > 0) ? ONE_Q : 0;
            end else begin
                bad = 1'b1;
            end
        end else begin
            case (cmd)
                CMD_ACT: begin
                    val = x;
                end
                CMD_SLOPE: begin
                    val = ONE_Q;
                end
                default: begin
                    val = f;
                end
            endcase
        end
        r.unsup = bad;
        r.sat   = 1'b0;
        if (val > 32767) begin
            val   = 32767;
            r.sat = 1'b1;
        end else if (val < -32768) begin
            val   = -32768;
            r.sat = 1'b1;
        end
        r.value = val[15:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0: begin
                v = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            end
            1: begin
                v = 16'($urandom_range(0, 64)) - 16'd32;
            end
            default: begin
                v = 16'($urandom());
            end
        endcase
        return v;
    endfunction

    // Lowers valid first so that a transfer already taken is not offered again.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(t_cfg_reg idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_KIND) begin
            act_kind = data[1:0];
        end else begin
            beta_gain = data;
        end
    endtask

    task automatic apply_setting(logic [1:0] kind, logic [15:0] beta);
        drain_results();
        // Only the low two bits of the kind register count.
        write_register(CFG_KIND, {14'($urandom()), kind});
        write_register(CFG_BETA, beta);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high after a transfer when the next item follows at once.
    task automatic send_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] f,
                             t_result want);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_x_value  <= x;
        i_factor   <= f;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(want);
    endtask

    initial begin : stimulus
        t_row        row;
        t_result     want;
        logic [1:0]  kind;
        logic [1:0]  cmd;
        logic [15:0] beta;
        int          count;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_ACT;
        i_x_value   <= '0;
        i_factor    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_KIND;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            if (row.kind != act_kind || row.beta != beta_gain) begin
                apply_setting(row.kind, row.beta);
            end
            if (row.lit) begin
                want = '{row.res, row.uns, row.sat};
            end else begin
                want = compute_activation_result(row.cmd, row.x, row.f);
            end
            send_item(row.cmd, row.x, row.f, want);
        end

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: begin kind = KIND_SIGMOID;  beta = BETA_RESET; end
                1: begin kind = KIND_SIGMOID;  beta = 16'hFFFF; end
                2: begin kind = KIND_SIGMOID;  beta = 16'h0000; end
                3: begin kind = KIND_STEP;     beta = 16'($urandom()); end
                4: begin kind = KIND_IDENTITY; beta = 16'($urandom()); end
                5: begin kind = KIND_SIGMOID;  beta = 16'($urandom_range(0, 8191)); end
                6: begin kind = KIND_BAD;      beta = 16'($urandom()); end
                8: begin kind = KIND_IDENTITY; beta = 16'hFFFF; end
                default: begin kind = KIND_SIGMOID; beta = 16'($urandom()); end
            endcase
            apply_setting(kind, beta);
            no_idle = ((p % 3) == 2);
            count   = (p == 6) ? 60 : 205;
            for (int n = 0; n < count; n++) begin
                // Sender holds off once mid-phase until the pipeline has emptied.
                if (p == 7 && n == count / 2) begin
                    drain_results();
                end
                cmd = ($urandom_range(0, 15) == 0) ? CMD_BAD : 2'($urandom_range(0, 2));
                row.x = pick_operand();
                row.f = pick_operand();
                send_item(cmd, row.x, row.f, compute_activation_result(cmd, row.x, row.f));
            end
        end

        drain_results();
        repeat (2 * NSTAGE) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : result_check
        int unsigned hold;
        t_result     want;
        i_out_ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: value %0d unsup %0b sat %0b",
                             o_result_value, o_unsupported, o_saturated);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value || o_unsupported !== want.unsup
                        || o_saturated !== want.sat) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("result mismatch: expected value %0d unsup %0b sat %0b, got value %0d unsup %0b sat %0b",
                                 want.value, want.unsup, want.sat,
                                 o_result_value, o_unsupported, o_saturated);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/awdu_pkg.sv
rtl/core/awdu_pipe_ctrl.sv
rtl/core/awdu_sigmoid.sv
rtl/core/awdu_deriv.sv
rtl/core/activation_with_derivative_unit_top.sv
dv/tb_top.sv
